// ===== hdl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    // Operation codes carried by the opcode field
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Fixed field widths of the channels and the configuration register
    localparam int OPCODE_W    = 2;
    localparam int ROW_KEY_W   = 32;
    localparam int ROW_PAY_W   = 64;
    localparam int FIRST_IDX_W = 6;
    localparam int COUNT_W     = 7;
    localparam int CAP_W       = 7;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [ROW_KEY_W-1:0] row_key;
        logic [ROW_PAY_W-1:0] row_payload;
    } req_t;

    typedef struct packed {
        logic                   status;
        logic                   found;
        logic [FIRST_IDX_W-1:0] first_index;
        logic [COUNT_W-1:0]     match_count;
        logic [ROW_PAY_W-1:0]   first_payload;
        logic [COUNT_W-1:0]     rows_held;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_HEAD,
        ST_LK_SEARCH,
        ST_LK_COUNT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/skt_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
`default_nettype none

interface skt_req_if;
    import skt_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface skt_rsp_if;
    import skt_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/skt_row_mem.sv =====
// Row memory: key and payload arrays, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module skt_row_mem #(
    parameter int DEPTH     = 64,
    parameter int KEY_W     = 32,
    parameter int PAYLOAD_W = 64,
    parameter int AW        = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [KEY_W-1:0]     wr_key,
    input  wire logic [PAYLOAD_W-1:0] wr_pay,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [KEY_W-1:0]     rd_key,
    output logic      [PAYLOAD_W-1:0] rd_pay
);

    logic [KEY_W-1:0]     key_mem [DEPTH];
    logic [PAYLOAD_W-1:0] pay_mem [DEPTH];
    logic [KEY_W-1:0]     rd_key_reg;
    logic [PAYLOAD_W-1:0] rd_pay_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;
    assign rd_pay = rd_pay_reg;

endmodule

`default_nettype wire

// ===== hdl/skt_ctrl.sv =====
// Sequencer: walks the row memory for insert and lookup, keeps the row count.
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl #(
    parameter int DEPTH     = 64,
    parameter int KEY_W     = 32,
    parameter int PAYLOAD_W = 64,
    parameter int AW        = $clog2(DEPTH),
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire skt_pkg::req_t               req,
    input  wire logic [skt_pkg::CAP_W-1:0]   capacity,
    input  wire logic                        slot_free,
    output logic                             in_ready,
    output logic                             res_valid,
    output skt_pkg::rsp_t                    res,
    output logic                             wr_en,
    output logic      [AW-1:0]               wr_addr,
    output logic      [KEY_W-1:0]            wr_key,
    output logic      [PAYLOAD_W-1:0]        wr_pay,
    output logic                             rd_en,
    output logic      [AW-1:0]               rd_addr,
    input  wire logic [KEY_W-1:0]            rd_key,
    input  wire logic [PAYLOAD_W-1:0]        rd_pay
);

    import skt_pkg::*;

    state_t               state_reg,  state_next;
    logic [CW-1:0]        count_reg,  count_next;
    logic [AW-1:0]        idx_reg,    idx_next;
    logic [KEY_W-1:0]     key_reg,    key_next;
    logic [PAYLOAD_W-1:0] pay_reg,    pay_next;
    logic                 status_reg, status_next;
    logic                 found_reg,  found_next;
    logic [AW-1:0]        first_reg,  first_next;
    logic [CW-1:0]        match_reg,  match_next;
    logic [PAYLOAD_W-1:0] fpay_reg,   fpay_next;

    logic [CW-1:0] idx_inc;
    logic          last_row;
    logic          key_gt;
    logic          key_eq;
    logic          full;

    assign idx_inc  = CW'(idx_reg) + CW'(1);
    assign last_row = (idx_inc >= count_reg);
    assign key_gt   = (rd_key > key_reg);
    assign key_eq   = (rd_key == key_reg);
    assign full     = (32'(count_reg) >= 32'(capacity)) || (32'(count_reg) >= DEPTH);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.opcode)
                        OP_INSERT:
                        begin
                            if (full)
                                state_next = ST_DONE;
                            else if (count_reg == '0)
                                state_next = ST_INS_HEAD;
                            else
                                state_next = ST_INS_SCAN;
                        end
                        OP_LOOKUP:
                            state_next = (count_reg == '0) ? ST_DONE : ST_LK_SEARCH;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_INS_SCAN:
            begin
                if (!key_gt)
                    state_next = ST_DONE;
                else if (idx_reg == '0)
                    state_next = ST_INS_HEAD;
            end
            ST_INS_HEAD:
                state_next = ST_DONE;
            ST_LK_SEARCH:
            begin
                if (key_gt || last_row)
                    state_next = ST_DONE;
                else if (key_eq)
                    state_next = ST_LK_COUNT;
            end
            ST_LK_COUNT:
            begin
                if (!key_eq || last_row)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory port control
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_key    = key_reg;
        wr_pay    = pay_reg;
        rd_en     = 1'b0;
        rd_addr   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // insert walks down from the top row, lookup up from row zero
                if (start && (count_reg != '0))
                begin
                    if (req.opcode == OP_INSERT && !full)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(count_reg - CW'(1));
                    end
                    else if (req.opcode == OP_LOOKUP)
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_INS_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_inc);
                if (key_gt)
                begin
                    // move the larger row up and fetch the one below it
                    wr_key = rd_key;
                    wr_pay = rd_pay;
                    if (idx_reg != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - AW'(1);
                    end
                end
            end
            ST_INS_HEAD:
                wr_en = 1'b1;
            ST_LK_SEARCH:
            begin
                if (!key_gt && !last_row)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_inc);
                end
            end
            ST_LK_COUNT:
            begin
                if (key_eq && !last_row)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_inc);
                end
            end
            ST_DONE:
                res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        status_next = status_reg;
        found_next  = found_reg;
        first_next  = first_reg;
        match_next  = match_reg;
        fpay_next   = fpay_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next    = KEY_W'(req.row_key);
                    pay_next    = PAYLOAD_W'(req.row_payload);
                    status_next = 1'b0;
                    found_next  = 1'b0;
                    first_next  = '0;
                    match_next  = '0;
                    fpay_next   = '0;
                    idx_next    = '0;
                    case (req.opcode)
                        OP_INSERT:
                        begin
                            idx_next    = AW'(count_reg - CW'(1));
                            status_next = full;
                        end
                        OP_CLEAR:
                            count_next = '0;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INS_SCAN:
            begin
                if (!key_gt)
                    count_next = count_reg + CW'(1);
                else if (idx_reg != '0)
                    idx_next = idx_reg - AW'(1);
            end
            ST_INS_HEAD:
                count_next = count_reg + CW'(1);
            ST_LK_SEARCH:
            begin
                if (key_eq)
                begin
                    found_next = 1'b1;
                    first_next = idx_reg;
                    fpay_next  = rd_pay;
                    match_next = CW'(1);
                end
                if (!key_gt && !last_row)
                    idx_next = AW'(idx_inc);
            end
            ST_LK_COUNT:
            begin
                if (key_eq)
                begin
                    match_next = match_reg + CW'(1);
                    if (!last_row)
                        idx_next = AW'(idx_inc);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        first_reg  <= first_next;
        match_reg  <= match_next;
        fpay_reg   <= fpay_next;
    end

    assign res.status        = status_reg;
    assign res.found         = found_reg;
    assign res.first_index   = FIRST_IDX_W'(first_reg);
    assign res.match_count   = COUNT_W'(match_reg);
    assign res.first_payload = ROW_PAY_W'(fpay_reg);
    assign res.rows_held     = COUNT_W'(count_reg);

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && (wr_addr == rd_addr)))
        else $error("row read and write hit the same address");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("row count beyond depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) <= 32'(count_reg)))
        else $error("row write above the filled region");

    a_refused_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && req.opcode == OP_INSERT && full)
        |=> (status_reg && count_reg == $past(count_reg) && state_reg == ST_DONE))
        else $error("refused insert changed the table");

endmodule

`default_nettype wire

// ===== hdl/sorted_key_table.sv =====
// Top level of the sorted key table: channels, capacity register, result register.
`timescale 1ns / 1ps
`default_nettype none

// Sorted key table. Rows of (key, payload) are held in ascending key order in a
// single-port-read, single-port-write row memory with a registered read port.
// Insert walks down from the top row, moving each larger row up by one, and drops
// the new row in behind every row with an equal or smaller key; it is refused with
// status 1 when the row count has reached min(capacity, DEPTH). Lookup walks up from
// row zero, stopping at the first larger key, and reports the first match, its payload
// and the length of the run of equal keys. Clear zeroes the row count only.
// Timing: the memory read port moves one row per cycle; clear, a refused insert or
// an unused opcode go straight from the accepting edge to the result being offered.
// One request is worked at a time; the next is accepted as soon as the previous
// result has moved into the output register, even while that result waits to be taken.
// The capacity register (reset 64) is written through cfg_we/cfg_wdata; the user
// must write it only while idle, and the block itself does not enforce this.
module sorted_key_table #(
    parameter int DEPTH     = 64,
    parameter int KEY_W     = 32,
    parameter int PAYLOAD_W = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    skt_req_if.sink                        req,
    skt_rsp_if.source                      rsp,
    input  wire logic                      cfg_we,
    input  wire logic [skt_pkg::CAP_W-1:0] cfg_wdata
);

    import skt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Capacity register
    logic [CAP_W-1:0] capacity_reg, capacity_next;

    // Output register: holds one finished result for the response channel
    logic out_valid_reg, out_valid_next;
    rsp_t out_data_reg,  out_data_next;

    // Sequencer to top level
    logic start;
    logic in_ready;
    logic res_valid;
    rsp_t res;
    logic slot_free;

    // Row memory ports
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_W-1:0]     wr_key;
    logic [PAYLOAD_W-1:0] wr_pay;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [KEY_W-1:0]     rd_key;
    logic [PAYLOAD_W-1:0] rd_pay;

    // A request transaction completes whenever the sequencer is idle and valid is up
    assign req.ready = in_ready;
    assign start     = req.valid && in_ready;

    // The output slot frees up when empty or when its transaction completes this cycle
    assign slot_free = !out_valid_reg || rsp.ready;

    assign capacity_next = cfg_we ? cfg_wdata : capacity_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && slot_free)
        begin
            // load the finished result, possibly in the same cycle as the old one leaves
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    skt_ctrl #(
        .DEPTH     (DEPTH),
        .KEY_W     (KEY_W),
        .PAYLOAD_W (PAYLOAD_W),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req.data),
        .capacity  (capacity_reg),
        .slot_free (slot_free),
        .in_ready  (in_ready),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_pay    (wr_pay),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_pay    (rd_pay)
    );

    skt_row_mem #(
        .DEPTH     (DEPTH),
        .KEY_W     (KEY_W),
        .PAYLOAD_W (PAYLOAD_W),
        .AW        (AW)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_pay  (wr_pay),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_pay  (rd_pay)
    );

endmodule

`default_nettype wire
